@@ hdl/xxh64_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// xxh64_pkg
// Shared types and constants for the streaming XXH64 hasher.
// ----------------------------------------------------------------------------
package xxh64_pkg;

    // XXH64 primes.
    localparam logic [63:0] PRIME1 = 64'd11400714785074694791;
    localparam logic [63:0] PRIME2 = 64'd14029467366897019727;
    localparam logic [63:0] PRIME3 = 64'd1609587929392839161;
    localparam logic [63:0] PRIME4 = 64'd9650029242287828579;
    localparam logic [63:0] PRIME5 = 64'd2870177450012600261;

    // Bytes in one full word.
    localparam logic [3:0] FULL_WORD_BYTES = 4'd8;

    // One classified item as held in the queue.
    typedef struct packed {
        logic [63:0] data_word;
        logic [3:0]  byte_count;
        logic        last;
    } xxh_item_t;

    // Request to the shared multiplier.
    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } xxh_mul_req_t;

    // Back-end sequencer states.
    typedef enum logic [17:0] {
        ST_IDLE  = 18'h00001,
        ST_LR1   = 18'h00002,
        ST_LR2   = 18'h00004,
        ST_FIN0  = 18'h00008,
        ST_M1    = 18'h00010,
        ST_M2    = 18'h00020,
        ST_M3    = 18'h00040,
        ST_LEN   = 18'h00080,
        ST_W1    = 18'h00100,
        ST_W2    = 18'h00200,
        ST_W3    = 18'h00400,
        ST_HALF  = 18'h00800,
        ST_HALF2 = 18'h01000,
        ST_B1    = 18'h02000,
        ST_B2    = 18'h04000,
        ST_AV1   = 18'h08000,
        ST_AV2   = 18'h10000,
        ST_AV3   = 18'h20000
    } xxh_state_t;

    // Rotate left by a constant amount in 1..63.
    function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned r);
        return (x << r) | (x >> (64 - r));
    endfunction

endpackage
`default_nettype wire

@@ hdl/xxh64_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// xxh64_front
// Accepts items, normalizes the byte count and queues them for the back end.
// ----------------------------------------------------------------------------
module xxh64_front (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [63:0]           s_data_word,
    input  wire logic [3:0]            s_byte_count,
    input  wire logic                  s_last,
    output logic                       q_valid,
    output xxh64_pkg::xxh_item_t       q_item,
    input  wire logic                  q_pop
);
    import xxh64_pkg::*;

    xxh_item_t  mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    xxh_item_t  item_in;

    // Only the last item may be partial; counts above eight saturate.
    always_comb begin
        item_in.data_word  = s_data_word;
        item_in.last       = s_last;
        if (!s_last || s_byte_count > FULL_WORD_BYTES) begin
            item_in.byte_count = FULL_WORD_BYTES;
        end else begin
            item_in.byte_count = s_byte_count;
        end
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = mem_reg[rd_ptr_reg];

    // Queue pointer and occupancy update.
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule
`default_nettype wire

@@ hdl/xxh64_mul.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// xxh64_mul
// 64x64 multiply modulo 2^64 built from three 32x32 partial products,
// one per cycle. The result is valid when done pulses.
// ----------------------------------------------------------------------------
module xxh64_mul (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire xxh64_pkg::xxh_mul_req_t req,
    output logic                       busy,
    output logic                       done,
    output logic [63:0]                result
);
    import xxh64_pkg::*;

    logic [63:0] a_reg, b_reg;
    logic [63:0] acc_reg, acc_next;
    logic [1:0]  ph_reg, ph_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [31:0] opx, opy;
    logic [63:0] prod;

    // Operand selection for the single 32x32 multiplier.
    always_comb begin
        case (ph_reg)
            2'd0:    begin opx = a_reg[31:0];  opy = b_reg[31:0];  end
            2'd1:    begin opx = a_reg[31:0];  opy = b_reg[63:32]; end
            default: begin opx = a_reg[63:32]; opy = b_reg[31:0];  end
        endcase
        prod = {32'd0, opx} * {32'd0, opy};
    end

    // Phase sequencing and accumulation.
    always_comb begin
        acc_next  = acc_reg;
        ph_next   = ph_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg) begin
            if (ph_reg == 2'd0) begin
                acc_next = prod;
            end else begin
                acc_next = acc_reg + {prod[31:0], 32'd0};
            end
            if (ph_reg == 2'd2) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                ph_next   = 2'd0;
            end else begin
                ph_next = ph_reg + 2'd1;
            end
        end else if (req.start) begin
            busy_next = 1'b1;
            ph_next   = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ph_reg   <= 2'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            ph_reg   <= ph_next;
        end
    end

    // Operand latch and accumulator.
    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        if (req.start && !busy_reg) begin
            a_reg <= req.a;
            b_reg <= req.b;
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = acc_reg;

endmodule
`default_nettype wire

@@ hdl/xxh64_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// xxh64_back
// Sequencer that folds stripes into the lanes and runs the final
// converge, tail and avalanche steps on the shared multiplier.
// ----------------------------------------------------------------------------
module xxh64_back (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [63:0]           seed,
    input  wire logic                  q_valid,
    input  wire xxh64_pkg::xxh_item_t  q_item,
    output logic                       q_pop,
    output xxh64_pkg::xxh_mul_req_t    mul_req,
    input  wire logic                  mul_done,
    input  wire logic [63:0]           mul_result,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [63:0]                m_hash_value
);
    import xxh64_pkg::*;

    xxh_state_t  state_reg, state_next;
    logic [63:0] lane_reg [4];
    logic [63:0] lane_next [4];
    logic [63:0] buf_reg [4];
    logic        buf_we;
    logic [63:0] len_reg, len_next;
    logic [63:0] h_reg, h_next;
    logic [63:0] tmp_reg, tmp_next;
    logic [63:0] w_reg, w_next;
    logic [2:0]  rem_reg, rem_next;
    logic [1:0]  fill_reg, fill_next;
    logic [1:0]  idx_reg, idx_next;
    logic [2:0]  bidx_reg, bidx_next;
    logic        used_reg, used_next;
    logic        fin_reg, fin_next;
    logic        issued_reg, issued_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_data_reg, out_data_next;
    logic [63:0] masked_word;
    logic [7:0]  cur_byte;

    // Keep only the valid low-order bytes of a partial word.
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            masked_word[b*8 +: 8] = (4'(b) < q_item.byte_count) ?
                                    q_item.data_word[b*8 +: 8] : 8'd0;
        end
    end

    assign cur_byte = 8'(w_reg >> {bidx_reg, 3'b000});

    // Main sequencer.
    always_comb begin
        state_next     = state_reg;
        for (int i = 0; i < 4; i++) begin
            lane_next[i] = lane_reg[i];
        end
        buf_we         = 1'b0;
        len_next       = len_reg;
        h_next         = h_reg;
        tmp_next       = tmp_reg;
        w_next         = w_reg;
        rem_next       = rem_reg;
        fill_next      = fill_reg;
        idx_next       = idx_reg;
        bidx_next      = bidx_reg;
        used_next      = used_reg;
        fin_next       = fin_reg;
        issued_next    = issued_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_ready;
        q_pop          = 1'b0;
        mul_req.start  = 1'b0;
        mul_req.a      = 64'd0;
        mul_req.b      = 64'd0;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop    = 1'b1;
                    len_next = len_reg + {60'd0, q_item.byte_count};
                    fin_next = q_item.last;
                    w_next   = masked_word;
                    if (q_item.byte_count == FULL_WORD_BYTES) begin
                        rem_next = 3'd0;
                        buf_we   = 1'b1;
                        if (fill_reg == 2'd3) begin
                            // Stripe complete: seed lanes on first use.
                            if (!used_reg) begin
                                lane_next[0] = seed + PRIME1 + PRIME2;
                                lane_next[1] = seed + PRIME2;
                                lane_next[2] = seed;
                                lane_next[3] = seed - PRIME1;
                                used_next    = 1'b1;
                            end
                            idx_next   = 2'd0;
                            state_next = ST_LR1;
                        end else begin
                            fill_next  = fill_reg + 2'd1;
                            state_next = q_item.last ? ST_FIN0 : ST_IDLE;
                        end
                    end else begin
                        rem_next   = q_item.byte_count[2:0];
                        state_next = ST_FIN0;
                    end
                end
            end
            ST_LR1: begin
                if (!issued_reg) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = buf_reg[idx_reg];
                    mul_req.b     = PRIME2;
                    issued_next   = 1'b1;
                end else if (mul_done) begin
                    issued_next = 1'b0;
                    tmp_next    = rotl(lane_reg[idx_reg] + mul_result, 31);
                    state_next  = ST_LR2;
                end
            end
            ST_LR2: begin
                if (!issued_reg) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = tmp_reg;
                    mul_req.b     = PRIME1;
                    issued_next   = 1'b1;
                end else if (mul_done) begin
                    issued_next        = 1'b0;
                    lane_next[idx_reg] = mul_result;
                    if (idx_reg == 2'd3) begin
                        fill_next  = 2'd0;
                        idx_next   = 2'd0;
                        state_next = fin_reg ? ST_FIN0 : ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = ST_LR1;
                    end
                end
            end
            ST_FIN0: begin
                // Converge the lanes, or start the short-message path.
                idx_next = 2'd0;
                if (used_reg) begin
                    h_next = rotl(lane_reg[0], 1) + rotl(lane_reg[1], 7)
                           + rotl(lane_reg[2], 12) + rotl(lane_reg[3], 18);
                    state_next = ST_M1;
                end else begin
                    h_next     = seed + PRIME5;
                    state_next = ST_LEN;
                end
            end
            ST_M1: begin
                if (!issued_reg) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = lane_reg[idx_reg];
                    mul_req.b     = PRIME2;
                    issued_next   = 1'b1;
                end else if (mul_done) begin
                    issued_next = 1'b0;
                    tmp_next    = rotl(mul_result, 31);
                    state_next  = ST_M2;
                end
            end
            ST_M2: begin
                if (!issued_reg) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = tmp_reg;
                    mul_req.b     = PRIME1;
                    issued_next   = 1'b1;
                end else if (mul_done) begin
                    issued_next = 1'b0;
                    h_next      = h_reg ^ mul_result;
                    state_next  = ST_M3;
                end
            end
            ST_M3: begin
                if (!issued_reg) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = h_reg;
                    mul_req.b     = PRIME1;
                    issued_next   = 1'b1;
                end else if (mul_done) begin
                    issued_next = 1'b0;
                    h_next      = mul_result + PRIME4;
                    if (idx_reg == 2'd3) begin
                        state_next = ST_LEN;
                    end else begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = ST_M1;
                    end
                end
            end
            ST_LEN: begin
                h_next     = h_reg + len_reg;
                idx_next   = 2'd0;
                state_next = (fill_reg != 2'd0) ? ST_W1 : ST_HALF;
            end
            ST_W1: begin
                if (!issued_reg) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = buf_reg[idx_reg];
                    mul_req.b     = PRIME2;
                    issued_next   = 1'b1;
                end else if (mul_done) begin
                    issued_next = 1'b0;
                    tmp_next    = rotl(mul_result, 31);
                    state_next  = ST_W2;
                end
            end
            ST_W2: begin
                if (!issued_reg) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = tmp_reg;
                    mul_req.b     = PRIME1;
                    issued_next   = 1'b1;
                end else if (mul_done) begin
                    issued_next = 1'b0;
                    h_next      = h_reg ^ mul_result;
                    state_next  = ST_W3;
                end
            end
            ST_W3: begin
                if (!issued_reg) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = rotl(h_reg, 27);
                    mul_req.b     = PRIME1;
                    issued_next   = 1'b1;
                end else if (mul_done) begin
                    issued_next = 1'b0;
                    h_next      = mul_result + PRIME4;
                    if ((idx_reg + 2'd1) == fill_reg) begin
                        state_next = ST_HALF;
                    end else begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = ST_W1;
                    end
                end
            end
            ST_HALF: begin
                if (rem_reg < 3'd4) begin
                    bidx_next  = 3'd0;
                    state_next = (rem_reg != 3'd0) ? ST_B1 : ST_AV1;
                end else if (!issued_reg) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = {32'd0, w_reg[31:0]};
                    mul_req.b     = PRIME1;
                    issued_next   = 1'b1;
                end else if (mul_done) begin
                    issued_next = 1'b0;
                    h_next      = h_reg ^ mul_result;
                    state_next  = ST_HALF2;
                end
            end
            ST_HALF2: begin
                if (!issued_reg) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = rotl(h_reg, 23);
                    mul_req.b     = PRIME2;
                    issued_next   = 1'b1;
                end else if (mul_done) begin
                    issued_next = 1'b0;
                    h_next      = mul_result + PRIME3;
                    bidx_next   = 3'd4;
                    state_next  = (rem_reg > 3'd4) ? ST_B1 : ST_AV1;
                end
            end
            ST_B1: begin
                if (!issued_reg) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = {56'd0, cur_byte};
                    mul_req.b     = PRIME5;
                    issued_next   = 1'b1;
                end else if (mul_done) begin
                    issued_next = 1'b0;
                    h_next      = h_reg ^ mul_result;
                    state_next  = ST_B2;
                end
            end
            ST_B2: begin
                if (!issued_reg) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = rotl(h_reg, 11);
                    mul_req.b     = PRIME1;
                    issued_next   = 1'b1;
                end else if (mul_done) begin
                    issued_next = 1'b0;
                    h_next      = mul_result;
                    if ((bidx_reg + 3'd1) == rem_reg) begin
                        state_next = ST_AV1;
                    end else begin
                        bidx_next  = bidx_reg + 3'd1;
                        state_next = ST_B1;
                    end
                end
            end
            ST_AV1: begin
                if (!issued_reg) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = h_reg ^ (h_reg >> 33);
                    mul_req.b     = PRIME2;
                    issued_next   = 1'b1;
                end else if (mul_done) begin
                    issued_next = 1'b0;
                    h_next      = mul_result;
                    state_next  = ST_AV2;
                end
            end
            ST_AV2: begin
                if (!issued_reg) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = h_reg ^ (h_reg >> 29);
                    mul_req.b     = PRIME3;
                    issued_next   = 1'b1;
                end else if (mul_done) begin
                    issued_next = 1'b0;
                    h_next      = mul_result;
                    state_next  = ST_AV3;
                end
            end
            ST_AV3: begin
                // Hand the digest to the output register and reset the message.
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = h_reg ^ (h_reg >> 32);
                    fill_next      = 2'd0;
                    len_next       = 64'd0;
                    used_next      = 1'b0;
                    fin_next       = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= 2'd0;
            len_reg       <= 64'd0;
            used_reg      <= 1'b0;
            fin_reg       <= 1'b0;
            issued_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            len_reg       <= len_next;
            used_reg      <= used_next;
            fin_reg       <= fin_next;
            issued_reg    <= issued_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers and stripe buffer.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < 4; i++) begin
            lane_reg[i] <= lane_next[i];
        end
        if (buf_we) begin
            buf_reg[fill_reg] <= q_item.data_word;
        end
        h_reg        <= h_next;
        tmp_reg      <= tmp_next;
        w_reg        <= w_next;
        rem_reg      <= rem_next;
        idx_reg      <= idx_next;
        bidx_reg     <= bidx_next;
        out_data_reg <= out_data_next;
    end

    assign m_valid      = out_valid_reg;
    assign m_hash_value = out_data_reg;

endmodule
`default_nettype wire

@@ hdl/xxh64_stream_hasher_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// xxh64_stream_hasher_unit
// Streaming XXH64 hasher with a writable seed.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (s_*) takes one 64-bit little-endian word per item with
//   a byte count and a last mark; only the last item may be partial.
//   The result channel (m_*) gives one 64-bit digest per message. The user must
//   write the seed through cfg_wr_en/cfg_wr_data only while idle (not enforced).
// Operation:
//   Items pass through a two-entry queue into a sequencer that owns one
//   shared multiplier, which takes one request at a time. A word that does not
//   complete a stripe is only stored; one that completes it runs eight products
//   (two per lane) before the sequencer takes the next item, while the queue
//   keeps accepting until full. The last item then runs the converge (or short-
//   message), tail and avalanche steps; the tail steps depend on its length.
// Reset and stall:
//   Reset clears the queue, message state, seed and output valid flag. A digest
//   waits in the output register while m_ready is low; the next message is
//   accepted and hashed meanwhile, up to the hand-off of its own digest.
// ----------------------------------------------------------------------------
module xxh64_stream_hasher_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [63:0] cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [63:0] s_data_word,
    input  wire logic [3:0]  s_byte_count,
    input  wire logic        s_last,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_hash_value
);
    import xxh64_pkg::*;

    logic [63:0]  seed_reg;
    logic         q_valid;
    xxh_item_t    q_item;
    logic         q_pop;
    xxh_mul_req_t mul_req;
    logic         mul_busy;
    logic         mul_done;
    logic [63:0]  mul_result;

    // Seed register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= 64'd0;
        end else if (cfg_wr_en) begin
            seed_reg <= cfg_wr_data;
        end
    end

    xxh64_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_word  (s_data_word),
        .s_byte_count (s_byte_count),
        .s_last       (s_last),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    xxh64_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .busy    (mul_busy),
        .done    (mul_done),
        .result  (mul_result)
    );

    xxh64_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .seed         (seed_reg),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .mul_req      (mul_req),
        .mul_done     (mul_done),
        .mul_result   (mul_result),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hash_value (m_hash_value)
    );

`ifndef SYNTH
    // The sequencer only takes an item that the queue holds.
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid) else $error("pop from empty queue");

    // A product is never requested while one is in flight.
    a_mul_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_req.start |-> !mul_busy) else $error("multiplier request overlap");

    // Every product request is answered by a done pulse.
    a_mul_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_req.start |-> ##4 mul_done) else $error("multiplier latency");
`endif

endmodule
`default_nettype wire
